// ===== design/gnmr_pkg.sv =====
// Package with the sample type and scan phase codes of the gamepad nibble responder.
`timescale 1ns / 1ps

package gnmr_pkg;

	// One registered sample of the console lines and the stick levels.
	typedef struct packed {
		logic       enable_n;
		logic       bank_select;
		logic [3:0] directions;
		logic [3:0] face_buttons;
		logic [3:0] extra_buttons;
	} sample_t;

	typedef logic [2:0] phase_t;

	// Scan phase codes; the two unused codes behave as idle.
	localparam phase_t PH_IDLE       = 3'd0;
	localparam phase_t PH_WAIT_DROP1 = 3'd1;
	localparam phase_t PH_ACTIVE1    = 3'd2;
	localparam phase_t PH_WAIT_EN2   = 3'd3;
	localparam phase_t PH_WAIT_DROP2 = 3'd4;
	localparam phase_t PH_ACTIVE_END = 3'd5;

	localparam logic [3:0] NIBBLE_ALL_HIGH = 4'hF;
	localparam logic [3:0] NIBBLE_ZERO     = 4'h0;

endpackage

// ===== design/gnmr_core.sv =====
// Scan state machine: phase, captured nibble and turbo phase, with the next output nibble.
`timescale 1ns / 1ps

module gnmr_core import gnmr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  sample_t    sample,
	input  logic       six_button_mode,
	input  logic [3:0] latch_cur,
	output logic [3:0] latch_next
);

	phase_t     phase_q;
	phase_t     phase_d;
	logic [3:0] pending_q;
	logic [3:0] pending_d;
	logic [1:0] turbo_q;
	logic [1:0] turbo_d;
	logic       gate_open;
	logic [3:0] gated;

	// Face buttons 3 and 2 pass when the turbo gate is open, in six-button mode,
	// or when extra button 1 or 2, respectively, is held.
	always_comb begin
		gate_open = ~turbo_q[1];
		gated[1:0] = sample.face_buttons[1:0];
		gated[3] = sample.face_buttons[3] &
			(six_button_mode | sample.extra_buttons[1] | gate_open);
		gated[2] = sample.face_buttons[2] &
			(six_button_mode | sample.extra_buttons[2] | gate_open);
	end

	// One transition per sample.
	always_comb begin
		phase_d    = phase_q;
		pending_d  = pending_q;
		turbo_d    = turbo_q;
		latch_next = latch_cur;
		case (phase_q)
			PH_WAIT_DROP1: begin
				if (!sample.bank_select) begin
					latch_next = pending_q;
					if (six_button_mode) begin
						phase_d = PH_ACTIVE1;
					end else begin
						turbo_d = turbo_q + 2'd1;
						phase_d = PH_ACTIVE_END;
					end
				end
			end
			PH_ACTIVE1: begin
				if (sample.enable_n) begin
					latch_next = NIBBLE_ZERO;
					phase_d    = PH_WAIT_EN2;
				end else if (sample.bank_select) begin
					latch_next = NIBBLE_ALL_HIGH;
				end
			end
			PH_WAIT_EN2: begin
				if (!sample.enable_n) begin
					pending_d = sample.extra_buttons;
					phase_d   = PH_WAIT_DROP2;
				end
			end
			PH_WAIT_DROP2: begin
				if (!sample.bank_select) begin
					latch_next = pending_q;
					phase_d    = PH_ACTIVE_END;
				end
			end
			PH_ACTIVE_END: begin
				if (sample.enable_n) begin
					latch_next = NIBBLE_ZERO;
					phase_d    = PH_IDLE;
				end else if (sample.bank_select) begin
					latch_next = NIBBLE_ALL_HIGH;
				end
			end
			default: begin
				latch_next = NIBBLE_ZERO;
				phase_d    = PH_IDLE;
				if (!sample.enable_n) begin
					latch_next = sample.directions;
					pending_d  = gated;
					phase_d    = PH_WAIT_DROP1;
				end
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			turbo_q <= 2'd0;
		end else if (step) begin
			phase_q <= phase_d;
			turbo_q <= turbo_d;
		end
	end

	// Captured nibble; always written when enable falls before it is read.
	always_ff @(posedge clk) begin
		if (step) begin
			pending_q <= pending_d;
		end
	end

endmodule

// ===== design/gamepad_nibble_mux_responder_top.sv =====
// Top level of the gamepad nibble responder: input register, scan logic and result register.
`timescale 1ns / 1ps

// Each accepted sample of the console lines gives exactly one data nibble. A sample
// is held in the input register and leaves through the result register, where its
// nibble stays offered until it is taken. One sample per clock is sustained while
// the output is not stalled; the scan state is updated between the two registers.
// The input stalls only when both registers hold a beat and the output is stalled.
// The mode register may be written at any idle time and is always ready; writing it
// does not disturb the scan state.
module gamepad_nibble_mux_responder_top import gnmr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       enable_n,
	input  logic       bank_select,
	input  logic [3:0] directions,
	input  logic [3:0] face_buttons,
	input  logic [3:0] extra_buttons,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] data_nibble,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       six_button_mode
);

	logic       mode_q;
	logic       valid_s1;
	sample_t    sample_s1;
	logic       out_valid_q;
	logic [3:0] latch_q;
	logic [3:0] latch_next;
	logic       advance;
	logic       step;
	logic       in_take;

	// Pipeline control: the input stage moves on when the result register is free or its beat is being taken.
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign data_nibble = latch_q;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= six_button_mode;
		end
	end

	// Input register valid and result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input sample payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1.enable_n      <= enable_n;
			sample_s1.bank_select   <= bank_select;
			sample_s1.directions    <= directions;
			sample_s1.face_buttons  <= face_buttons;
			sample_s1.extra_buttons <= extra_buttons;
		end
	end

	// The result register is also the driven output latch of the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= NIBBLE_ZERO;
		end else if (step) begin
			latch_q <= latch_next;
		end
	end

	gnmr_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.sample          (sample_s1),
		.six_button_mode (mode_q),
		.latch_cur       (latch_q),
		.latch_next      (latch_next)
	);

endmodule

// ===== design/gnmr_checker.sv =====
// Port-level checker for the gamepad nibble responder and its bind to the top level.
`timescale 1ns / 1ps

module gnmr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] data_nibble,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	// A stalled result beat stays offered with the same nibble.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_nibble))
		else $error("stalled result beat changed or vanished");

	// The input only stalls behind a full, stalled result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the result side can move");

	// With no result beat offered, the input is never stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with no result offered");

	// The mode register write channel never back-pressures.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("mode register write not taken");

endmodule

bind gamepad_nibble_mux_responder_top gnmr_checker u_gnmr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.data_nibble (data_nibble),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready)
);
